>>> src/gdr_pkg.sv
// gdr_pkg: constants and types for the grid dda column raycaster
// no dependencies
package gdr_pkg;

    localparam int ScreenWidth  = 1024;
    localparam int ScreenHeight = 1024;
    localparam int MapDim       = 64;
    localparam int HorizonShift = 100;

    localparam int MapAw   = $clog2(MapDim);
    localparam int CellAw  = 2 * MapAw;
    localparam int CellW   = 4;
    localparam int SwW     = $clog2(ScreenWidth);
    localparam int CamShift = SwW - 17;

    localparam logic [23:0] DistMax   = 24'hFFFFFF;
    localparam logic [15:0] HeightMax = 16'hFFFF;
    localparam int          Row0      = ScreenHeight / 2 - HorizonShift;

    // register indexes
    localparam logic [2:0] RegPlayerX = 3'd0;
    localparam logic [2:0] RegPlayerY = 3'd1;
    localparam logic [2:0] RegDirX    = 3'd2;
    localparam logic [2:0] RegDirY    = 3'd3;
    localparam logic [2:0] RegPlaneX  = 3'd4;
    localparam logic [2:0] RegPlaneY  = 3'd5;

    // sequencer states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RAY   = 11'b00000000010,
        S_DIVX  = 11'b00000000100,
        S_DIVY  = 11'b00000001000,
        S_INIT  = 11'b00000010000,
        S_STEP  = 11'b00000100000,
        S_READ  = 11'b00001000000,
        S_TEST  = 11'b00010000000,
        S_HDIV  = 11'b00100000000,
        S_ROWS  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    // divider control
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [33:0] den;
    } t_div_req;

endpackage

>>> src/grid_dda_column_raycaster_top.sv
// grid dda column raycaster: writes map cells and casts one ray per screen column
// a cast waits on the divider for the two step lengths and, on a hit at nonzero distance, the slice
// height, and does a step, a map read and a test per grid step, up to 2*MapDim steps
// one item at a time: busy is high from a cast's acceptance until the result strobe
// synchronous active low reset restores the register defaults; map is undefined until written
// depends on gdr_pkg, gdr_ram, gdr_div
module grid_dda_column_raycaster_top
    import gdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic [3:0]  i_cell_value,
    input  logic [9:0]  i_screen_column,
    output logic        o_valid,
    output logic [5:0]  o_hit_row,
    output logic [5:0]  o_hit_col,
    output logic        o_hit_side,
    output logic [23:0] o_wall_distance,
    output logic [15:0] o_slice_height,
    output logic [9:0]  o_slice_top,
    output logic [9:0]  o_slice_bottom,
    output logic        o_escaped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_state r_state;

    logic [21:0] r_px, r_py;
    logic signed [15:0] r_dx, r_dy, r_cx, r_cy;

    logic signed [33:0] r_rx, r_ry;
    logic signed [17:0] w_cam;
    logic [23:0] r_dlx, r_dly;
    logic [31:0] r_sdx, r_sdy;
    logic signed [8:0] r_mx, r_my;
    logic r_side;
    logic [9:0] r_col;
    logic [23:0] r_dist;
    logic [15:0] r_height;
    logic r_escaped;

    t_div_req w_div;
    logic     w_div_done;
    logic [47:0] w_quot;

    logic        w_ram_we;
    logic [CellAw-1:0] w_ram_addr;
    logic [CellW-1:0]  w_ram_rd;

    logic w_accept, w_wr;
    logic [2:0] w_reg;

    // helpers for the walk
    logic [23:0] w_dlen;
    logic [23:0] w_dist_n;
    logic [16:0] w_fx, w_fy;
    logic [40:0] w_ix, w_iy;
    logic [32:0] w_dsub;
    logic signed [8:0] w_nmx, w_nmy;
    logic w_out;
    logic signed [17:0] w_top, w_bot;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_reg    = paddr[4:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= 22'd98304;
            r_py <= 22'd98304;
            r_dx <= 16'sd16384;
            r_dy <= '0;
            r_cx <= '0;
            r_cy <= 16'sd10813;
        end else if (w_wr) begin
            unique case (w_reg)
                RegPlayerX: r_px <= pwdata[21:0];
                RegPlayerY: r_py <= pwdata[21:0];
                RegDirX:    r_dx <= pwdata[15:0];
                RegDirY:    r_dy <= pwdata[15:0];
                RegPlaneX:  r_cx <= pwdata[15:0];
                RegPlaneY:  r_cy <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            RegPlayerX: prdata = {10'd0, r_px};
            RegPlayerY: prdata = {10'd0, r_py};
            RegDirX:    prdata = {{16{r_dx[15]}}, r_dx};
            RegDirY:    prdata = {{16{r_dy[15]}}, r_dy};
            RegPlaneX:  prdata = {{16{r_cx[15]}}, r_cx};
            RegPlaneY:  prdata = {{16{r_cy[15]}}, r_cy};
            default:    prdata = '0;
        endcase
    end

    // map memory: write items address it directly, the walk reads it
    assign w_ram_we   = w_accept && !i_req_type && (i_cell_row < 7'(MapDim))
                        && (i_cell_col < 7'(MapDim));
    assign w_ram_addr = (r_state == S_IDLE)
                        ? {i_cell_row[MapAw-1:0], i_cell_col[MapAw-1:0]}
                        : {r_my[MapAw-1:0], r_mx[MapAw-1:0]};

    gdr_ram #(.Width(CellW), .Depth(MapDim * MapDim)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_cell_value),
        .o_rdata (w_ram_rd)
    );

    // shared divider
    logic [33:0] w_mag_x, w_mag_y;
    assign w_mag_x = r_rx[33] ? 34'(-r_rx) : 34'(r_rx);
    assign w_mag_y = r_ry[33] ? 34'(-r_ry) : 34'(r_ry);

    always_comb begin
        w_div.start = 1'b0;
        w_div.num   = 48'h4000_0000_0000;
        w_div.den   = w_mag_x;
        priority if (r_state == S_RAY) begin
            w_div.start = 1'b1;
        end else if (r_state == S_DIVX && w_div_done) begin
            w_div.start = 1'b1;
            w_div.den   = w_mag_y;
        end else if (r_state == S_TEST && w_ram_rd != '0 && w_dist_n != '0) begin
            w_div.start = 1'b1;
            w_div.num   = 48'(ScreenHeight) << 16;
            w_div.den   = {10'd0, w_dist_n};
        end
    end

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_dlen = (w_quot > 48'(DistMax)) ? DistMax : w_quot[23:0];
    assign w_fx   = r_rx[33] ? {1'b0, r_px[15:0]} : 17'h10000 - {1'b0, r_px[15:0]};
    assign w_fy   = r_ry[33] ? {1'b0, r_py[15:0]} : 17'h10000 - {1'b0, r_py[15:0]};
    assign w_ix   = w_fx * r_dlx;
    assign w_iy   = w_fy * r_dly;
    assign w_dsub = r_side ? ({1'b0, r_sdy} - {9'd0, r_dly})
                           : ({1'b0, r_sdx} - {9'd0, r_dlx});
    assign w_dist_n = (w_dsub > 33'(DistMax)) ? DistMax : w_dsub[23:0];
    assign w_nmx  = r_mx + (r_rx[33] ? -9'sd1 : 9'sd1);
    assign w_nmy  = r_my + (r_ry[33] ? -9'sd1 : 9'sd1);
    assign w_out  = r_mx < 0 || r_my < 0
                    || r_mx >= $signed(9'(MapDim)) || r_my >= $signed(9'(MapDim));
    assign w_top  = 18'(Row0) - 18'({1'b0, r_height[15:1]});
    assign w_bot  = 18'(Row0) + 18'({1'b0, r_height[15:1]});

    // camera coordinate: 2*col*65536/ScreenWidth - 65536
    assign w_cam = 18'(({17'd0, i_screen_column} << 17) >> SwW) - 18'sd65536;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_accept && i_req_type) r_state <= S_RAY;
                S_RAY:  r_state <= S_DIVX;
                S_DIVX: if (w_div_done) r_state <= S_DIVY;
                S_DIVY: if (w_div_done) r_state <= S_INIT;
                S_INIT: r_state <= w_out ? S_OUT : S_STEP;
                S_STEP: r_state <= S_READ;
                S_READ: r_state <= w_out ? S_OUT : S_TEST;
                S_TEST: begin
                    if (w_ram_rd == '0) r_state <= S_STEP;
                    else if (w_dist_n == '0) r_state <= S_ROWS;
                    else r_state <= S_HDIV;
                end
                S_HDIV: if (w_div_done) r_state <= S_ROWS;
                S_ROWS: r_state <= S_OUT;
                S_OUT: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_col     <= i_screen_column;
                r_escaped <= 1'b0;
                r_rx <= 34'(r_dx) * 34'sd65536 + 34'(r_cx) * 34'(w_cam);
                r_ry <= 34'(r_dy) * 34'sd65536 + 34'(r_cy) * 34'(w_cam);
            end
            // player cell loads with the ray
            S_RAY: begin
                r_mx <= 9'({3'd0, r_px[21:16]});
                r_my <= 9'({3'd0, r_py[21:16]});
            end
            S_DIVX: if (w_div_done) r_dlx <= (r_rx == 0) ? DistMax : w_dlen;
            S_DIVY: if (w_div_done) r_dly <= (r_ry == 0) ? DistMax : w_dlen;
            S_INIT: begin
                r_sdx <= 32'(w_ix >> 16);
                r_sdy <= 32'(w_iy >> 16);
                if (w_out) r_escaped <= 1'b1;
            end
            S_STEP: begin
                if (r_sdx < r_sdy) begin
                    r_sdx  <= r_sdx + 32'(r_dlx);
                    r_mx   <= w_nmx;
                    r_side <= 1'b0;
                end else begin
                    r_sdy  <= r_sdy + 32'(r_dly);
                    r_my   <= w_nmy;
                    r_side <= 1'b1;
                end
            end
            S_READ: if (w_out) r_escaped <= 1'b1;
            S_TEST: begin
                r_dist   <= w_dist_n;
                r_height <= HeightMax;
            end
            S_HDIV: if (w_div_done)
                r_height <= (w_quot > 48'(HeightMax)) ? HeightMax : w_quot[15:0];
            S_ROWS: begin
                o_slice_top    <= w_top < 0 ? 10'd0 : w_top[9:0];
                o_slice_bottom <= w_bot >= $signed(18'(ScreenHeight)) ? 10'(ScreenHeight - 1)
                                : (w_bot < 0 ? 10'd0 : w_bot[9:0]);
            end
            S_OUT: begin
                o_escaped       <= r_escaped;
                o_hit_row       <= r_escaped ? 6'd0 : 6'(r_my);
                o_hit_col       <= r_escaped ? 6'd0 : 6'(r_mx);
                o_hit_side      <= r_escaped ? 1'b0 : r_side;
                o_wall_distance <= r_escaped ? 24'd0 : r_dist;
                o_slice_height  <= r_escaped ? 16'd0 : r_height;
                if (r_escaped) begin
                    o_slice_top    <= '0;
                    o_slice_bottom <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/gdr_ram.sv
// gdr_ram: generic single port ram with registered read
// no dependencies
module gdr_ram #(
    parameter int Width = 4,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // read before write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/gdr_div.sv
// gdr_div: restoring divider, one quotient bit per cycle, for a 48-bit quotient
// depends on gdr_pkg
module gdr_div
    import gdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [47:0] r_quot, n_quot;
    logic [34:0] r_rem, n_rem;
    logic [33:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [34:0] w_trial;
    logic [34:0] w_sub;

    always_comb begin
        w_trial = {r_rem[33:0], r_quot[47]};
        w_sub   = w_trial - {1'b0, r_den};
        n_quot  = {r_quot[46:0], ~w_sub[34]};
        n_rem   = w_sub[34] ? w_trial : w_sub;
    end

    // iterate one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.num;
            r_rem  <= '0;
            r_den  <= i_req.den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> src/gdr_checker.sv
// gdr_checker: port level checks for the raycaster top level
// depends on gdr_pkg; bound to grid_dda_column_raycaster_top
module gdr_checker
    import gdr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_req_type,
    input logic        o_valid,
    input logic        o_escaped,
    input logic [23:0] o_wall_distance,
    input logic [15:0] o_slice_height,
    input logic [9:0]  o_slice_top,
    input logic [9:0]  o_slice_bottom,
    input logic        pready
);
    // a result word only ends a busy period
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result word without a cast");

    // a cast makes the block busy next cycle
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> busy) else $error("cast not taken");

    // escaped words carry zero payload
    a_esc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_escaped) |-> (o_wall_distance == 0 && o_slice_height == 0))
        else $error("escaped word has payload");

    // slice rows are ordered
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_escaped) |-> (o_slice_top <= o_slice_bottom))
        else $error("slice rows out of order");

    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind grid_dda_column_raycaster_top gdr_checker u_gdr_checker (.*);

>>> tb/tb_top.sv
// tb_top: self-checking testbench for grid_dda_column_raycaster_top
// holds its own DDA ray walk predictor in a scoreboard class; depends on gdr_pkg and the RTL
`timescale 1ns / 1ps

module tb_top;
    import gdr_pkg::*;

    // one expected cast result
    typedef struct packed {
        logic [5:0]  hit_row;
        logic [5:0]  hit_col;
        logic        hit_side;
        logic [23:0] wall_distance;
        logic [15:0] slice_height;
        logic [9:0]  slice_top;
        logic [9:0]  slice_bottom;
        logic        escaped;
    } t_hit;

    class raycast_scoreboard;
        logic [3:0]         cells [4096];
        logic [21:0]        pos_x, pos_y;
        logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
        t_hit               pending_hits [$];
        int                 mismatches;

        function new();
            pos_x = 22'd98304;
            pos_y = 22'd98304;
            dir_x = 16'sd16384;
            dir_y = 16'sd0;
            plane_x = 16'sd0;
            plane_y = 16'sd10813;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                RegPlayerX: pos_x = val[21:0];
                RegPlayerY: pos_y = val[21:0];
                RegDirX:    dir_x = val[15:0];
                RegDirY:    dir_y = val[15:0];
                RegPlaneX:  plane_x = val[15:0];
                RegPlaneY:  plane_y = val[15:0];
                default: ;
            endcase
        endfunction

        // step length across one cell for a ray component, saturating
        function longint cell_span(longint comp);
            longint mag;
            longint q;
            if (comp == 0) return 64'hFFFFFF;
            mag = comp < 0 ? -comp : comp;
            q = (64'sd1 <<< 46) / mag;
            return q > 64'hFFFFFF ? 64'hFFFFFF : q;
        endfunction

        // accepted word: map writes update the map, casts queue a predicted hit
        function void note_item(logic req, logic [5:0] r, logic [5:0] c, logic [3:0] v,
                                logic [9:0] column);
            t_hit   h;
            longint cam, rx, ry, dxl, dyl, sdx, sdy, fx, fy, wall_dist, height, hh, top, bot;
            int     mx, my, sx, sy, side;
            bit     hit;
            if (!req) begin
                cells[{r, c}] = v;
                return;
            end
            h = '0;
            cam = longint'(column) * 128 - 65536;
            rx = longint'(dir_x) * 65536 + longint'(plane_x) * cam;
            ry = longint'(dir_y) * 65536 + longint'(plane_y) * cam;
            dxl = cell_span(rx);
            dyl = cell_span(ry);
            mx = pos_x[21:16];
            my = pos_y[21:16];
            fx = pos_x[15:0];
            fy = pos_y[15:0];
            if (rx < 0) begin sx = -1; sdx = (fx * dxl) >> 16; end
            else begin sx = 1; sdx = ((65536 - fx) * dxl) >> 16; end
            if (ry < 0) begin sy = -1; sdy = (fy * dyl) >> 16; end
            else begin sy = 1; sdy = ((65536 - fy) * dyl) >> 16; end
            hit = 0;
            side = 0;
            // grid walk until a wall or the map edge
            while (!hit) begin
                if (sdx < sdy) begin
                    sdx += dxl; mx += sx; side = 0;
                end else begin
                    sdy += dyl; my += sy; side = 1;
                end
                if (mx < 0 || my < 0 || mx >= MapDim || my >= MapDim) begin
                    h.escaped = 1'b1;
                    pending_hits.push_back(h);
                    return;
                end
                if (cells[my * 64 + mx] > 0) hit = 1;
            end
            wall_dist = side == 0 ? sdx - dxl : sdy - dyl;
            if (wall_dist > 64'hFFFFFF) wall_dist = 64'hFFFFFF;
            if (wall_dist == 0) height = 65535;
            else begin
                height = (longint'(ScreenHeight) * 65536) / wall_dist;
                if (height > 65535) height = 65535;
            end
            hh = height / 2;
            top = Row0 - hh;
            bot = Row0 + hh;
            if (top < 0) top = 0;
            if (bot >= ScreenHeight) bot = ScreenHeight - 1;
            if (bot < 0) bot = 0;
            h.hit_row = my[5:0];
            h.hit_col = mx[5:0];
            h.hit_side = side[0];
            h.wall_distance = wall_dist[23:0];
            h.slice_height = height[15:0];
            h.slice_top = top[9:0];
            h.slice_bottom = bot[9:0];
            pending_hits.push_back(h);
        endfunction

        function void check_hit(t_hit got);
            t_hit want;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
                return;
            end
            want = pending_hits.pop_front();
            if (got.hit_row != want.hit_row || got.hit_col != want.hit_col ||
                got.hit_side != want.hit_side || got.wall_distance != want.wall_distance ||
                got.slice_height != want.slice_height || got.slice_top != want.slice_top ||
                got.slice_bottom != want.slice_bottom || got.escaped != want.escaped) begin
                mismatches++;
                if (mismatches <= 10) $display("result differs: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_req_type = 0;
    logic [5:0]  i_cell_row = 0;
    logic [5:0]  i_cell_col = 0;
    logic [3:0]  i_cell_value = 0;
    logic [9:0]  i_screen_column = 0;
    logic        o_valid;
    logic [5:0]  o_hit_row, o_hit_col;
    logic        o_hit_side, o_escaped;
    logic [23:0] o_wall_distance;
    logic [15:0] o_slice_height;
    logic [9:0]  o_slice_top, o_slice_bottom;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    // map blocks that casts stay inside: walls on every inner edge
    int          blk_base [3] = '{0, 28, 56};

    raycast_scoreboard sb = new();

    grid_dda_column_raycaster_top uut (.*);

    always #2 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_hit({o_hit_row, o_hit_col, o_hit_side, o_wall_distance,
                          o_slice_height, o_slice_top, o_slice_bottom, o_escaped});
    end

    // run limit
    initial begin
        #20000000;
        $display("grid_dda_column_raycaster_top: mismatch");
        $finish;
    end

    // open cells of a block; the rest of the block is its wall ring
    function automatic int blk_lo(int base);
        return (base == 0) ? 0 : base + 1;
    endfunction

    function automatic int blk_hi(int base);
        return (base == MapDim - 8) ? MapDim - 1 : base + 6;
    endfunction

    function automatic logic [5:0] blk_cell(int base);
        return 6'(blk_lo(base) + int'($urandom_range(0, blk_hi(base) - blk_lo(base))));
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // present one word, hold until accepted
    task automatic send_word(logic req, logic [5:0] r, logic [5:0] c, logic [3:0] v,
                             logic [9:0] column, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1; i_req_type = req; i_cell_row = r; i_cell_col = c;
        i_cell_value = v; i_screen_column = column;
        while (busy) @(negedge i_clk);
        sb.note_item(req, r, c, v, column);
        @(posedge i_clk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start = 0;
        while (sb.pending_hits.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (800) @(negedge i_clk);
    endtask

    task automatic set_view(logic [21:0] px, logic [21:0] py, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] plx, logic [15:0] ply);
        drain();
        apb_write(RegPlayerX, {10'h0, px});
        apb_write(RegPlayerY, {10'h0, py});
        apb_write(RegDirX, {16'h0, dx});
        apb_write(RegDirY, {16'h0, dy});
        apb_write(RegPlaneX, {16'h0, plx});
        apb_write(RegPlaneY, {16'h0, ply});
    endtask

    // load one block: ring cells are walls, open cells mostly empty
    task automatic fill_block(int base);
        logic [3:0] v;
        for (int r = base; r < base + 8; r++)
            for (int c = base; c < base + 8; c++) begin
                if (r < blk_lo(base) || r > blk_hi(base) || c < blk_lo(base)
                    || c > blk_hi(base))
                    v = 4'($urandom_range(1, 15));
                else
                    v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
                send_word(1'b0, 6'(r), 6'(c), v, 10'($urandom), 0);
            end
    endtask

    // random mix of map edits inside the block and casts, with a few fixed columns
    task automatic run_phase(int count, int base);
        int gap;
        logic [9:0] cols [6] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd513, 10'd1023};
        foreach (cols[k])
            send_word(1'b1, 6'($urandom), 6'($urandom), 4'($urandom), cols[k], 0);
        for (int n = 0; n < count; n++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0)
                send_word(1'b0, blk_cell(base), blk_cell(base),
                          ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd0,
                          10'($urandom), gap);
            else
                send_word(1'b1, 6'($urandom), 6'($urandom), 4'($urandom),
                          10'($urandom), gap);
        end
    endtask

    function automatic logic [21:0] rand_pos(int base);
        return {blk_cell(base), ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom)};
    endfunction

    initial begin
        int base;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        // fill the blocks so no cast reads an unwritten cell
        foreach (blk_base[b])
            fill_block(blk_base[b]);
        // directed edge cells
        send_word(1'b0, 6'd63, 6'd63, 4'd15, 10'd1023, 0);
        send_word(1'b0, 6'd0, 6'd0, 4'd0, 10'd0, 0);
        // reset view, then extreme views, a centred view, then random views
        run_phase(35, 0);
        set_view(22'd0, 22'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        run_phase(35, 0);
        set_view(22'h3FFFFF, 22'h3FFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        run_phase(35, 56);
        set_view({6'd32, 16'd0}, {6'd32, 16'd0}, 16'h0000, 16'd16384, 16'hD5C3, 16'h0000);
        run_phase(35, 28);
        for (int p = 0; p < 7; p++) begin
            base = blk_base[$urandom_range(0, 2)];
            set_view(rand_pos(base), rand_pos(base), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
            run_phase(35, base);
        end
        drain();
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
            $display("grid_dda_column_raycaster_top: match");
        else
            $display("grid_dda_column_raycaster_top: mismatch");
        $finish;
    end

endmodule
